// File: rtl/core/gpio_bank_irq_controller_macros.svh
// Assertion macros for the GPIO bank interrupt controller.
// Expects signals named clock and reset in the scope of each use.
`ifndef GPIO_BANK_IRQ_CONTROLLER_MACROS_SVH
`define GPIO_BANK_IRQ_CONTROLLER_MACROS_SVH

// same-cycle implication
`define GBIC_ASSERT_IMP(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("gbic: same-cycle check failed");

// next-cycle implication
`define GBIC_ASSERT_NXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("gbic: next-cycle check failed");

`endif

// File: rtl/core/gbic_pkg.sv
// Package for the GPIO bank interrupt controller: item types, register map codes,
// bank state struct and mask tables. No dependencies.
package gbic_pkg;

   localparam int NUM_BANKS      = 4;
   localparam int NUM_DRIVE_REGS = 15;
   localparam int NUM_MUX_REGS   = 8;
   localparam int NUM_PULL_REGS  = 4;
   localparam int IRQ_W          = 4;

   localparam logic [31:0] CTRL_SFT        = 32'h8000_0000;
   localparam logic [31:0] CTRL_GATE       = 32'h4000_0000;
   localparam logic [31:0] CTRL_PRESENT    = 32'h1C00_0000;
   localparam logic [31:0] DRIVE_MASK_FULL = 32'h7777_7777;
   localparam logic [31:0] DRIVE_MASK_7    = 32'h0007_7777;
   localparam logic [31:0] DRIVE_MASK_14   = 32'h0077_7777;
   localparam logic [31:0] DRIVE_RESET_PAT = 32'h4444_4444;

   // low nibble of the offset
   localparam logic [3:0] OP_PLAIN = 4'h0;
   localparam logic [3:0] OP_SET   = 4'h4;
   localparam logic [3:0] OP_CLR   = 4'h8;
   localparam logic [3:0] OP_TOG   = 4'hC;

   // register groups, offset bits 12..8
   localparam logic [4:0] GRP_CTRL     = 5'd0;
   localparam logic [4:0] GRP_MUX      = 5'd1;
   localparam logic [4:0] GRP_DRIVE    = 5'd2;
   localparam logic [4:0] GRP_PULL     = 5'd3;
   localparam logic [4:0] GRP_DOUT     = 5'd4;
   localparam logic [4:0] GRP_DIN      = 5'd5;
   localparam logic [4:0] GRP_DOE      = 5'd6;
   localparam logic [4:0] GRP_PIN2IRQ  = 5'd7;
   localparam logic [4:0] GRP_IRQEN    = 5'd8;
   localparam logic [4:0] GRP_IRQLEVEL = 5'd9;
   localparam logic [4:0] GRP_IRQPOL   = 5'd10;
   localparam logic [4:0] GRP_IRQSTAT  = 5'd11;

   typedef enum logic [1:0] {
      REQ_READ  = 2'd0,
      REQ_WRITE = 2'd1,
      REQ_PAD   = 2'd2,
      REQ_IDLE  = 2'd3
   } req_kind_type;

   typedef struct packed {
      req_kind_type req_type;
      logic [12:0]  offset;
      logic [31:0]  write_data;
      logic [1:0]   pad_bank;
      logic [31:0]  pad_levels;
   } gbic_req_type;

   typedef struct packed {
      logic [31:0]      read_data;
      logic [IRQ_W-1:0] irq_lines;
      logic             access_error;
   } gbic_rsp_type;

   typedef struct packed {
      logic [31:0] dout;
      logic [31:0] pad;
      logic [31:0] doe;
      logic [31:0] prev;
      logic [31:0] sel;
      logic [31:0] en;
      logic [31:0] lvl;
      logic [31:0] pol;
      logic [31:0] stat;
   } gbic_bank_type;

   function automatic logic [31:0] valid_mask(input int b);
      logic [31:0] m;
      unique case (b)
         0:       m = 32'h3FFF_FFFF;
         1:       m = 32'h1FFF_FFFF;
         2:       m = 32'hFFFF_FFFF;
         default: m = 32'h0000_0000;
      endcase
      return m;
   endfunction

   function automatic logic [31:0] pull_fld_mask(input int k);
      logic [31:0] m;
      unique case (k)
         0:       m = 32'h3c10_00fe;
         1:       m = 32'h0f40_0000;
         2:       m = 32'h0000_4000;
         default: m = 32'h0003_ffff;
      endcase
      return m;
   endfunction

   function automatic logic [31:0] drive_fld_mask(input int k);
      logic [31:0] m;
      unique case (k)
         7:       m = DRIVE_MASK_7;
         14:      m = DRIVE_MASK_14;
         default: m = DRIVE_MASK_FULL;
      endcase
      return m;
   endfunction

   // plain masked write or set/clear/toggle alias
   function automatic logic [31:0] apply_op(input logic [31:0] r, input logic [31:0] m,
                                            input logic [31:0] v, input logic [3:0] op);
      logic [31:0] res;
      unique case (op)
         OP_SET:  res = r | (v & m);
         OP_CLR:  res = r & ~(v & m);
         OP_TOG:  res = r ^ (v & m);
         default: res = (v & m) | (r & ~m);
      endcase
      return res;
   endfunction

endpackage

// File: rtl/core/gbic_bank_irq.sv
// Input resampling and interrupt status update for one GPIO bank.
// Depends on gbic_pkg.
module gbic_bank_irq (
   input  gbic_pkg::gbic_bank_type bank_pre,
   input  logic [31:0]             pin_mask,
   output gbic_pkg::gbic_bank_type bank_post
);
   import gbic_pkg::*;

   logic [31:0] now_pin;
   logic [31:0] prev_pin;
   logic [31:0] act_now;
   logic [31:0] act_prev;
   logic [31:0] lvl_sel;
   logic [31:0] edg_sel;

   always_comb begin
      now_pin  = (bank_pre.pad | (bank_pre.dout & bank_pre.doe)) & pin_mask;
      prev_pin = bank_pre.prev & pin_mask;
      act_now  = ~(now_pin ^ bank_pre.pol) & pin_mask;
      act_prev = ~(prev_pin ^ bank_pre.pol) & pin_mask;
      lvl_sel  = pin_mask & bank_pre.lvl & bank_pre.sel;
      edg_sel  = pin_mask & ~bank_pre.lvl & bank_pre.sel;
      bank_post      = bank_pre;
      bank_post.stat = (bank_pre.stat & ~lvl_sel) | (lvl_sel & act_now)
                     | (edg_sel & act_now & ~act_prev & (now_pin ^ prev_pin));
      bank_post.prev = now_pin;
   end

endmodule

// File: rtl/core/gpio_bank_irq_controller.sv
// GPIO bank and pad-control register block with per-pin interrupts; uses gbic_pkg, gbic_bank_irq.
// The input register holds the item and the result register its result; a stalled output holds both.
// Throughput: one item per cycle unless stalled; update and result share one combinational pass.
// Reset (synchronous) clears the pipeline and puts every map register at its reset value;
// a CTRL write leaving SFTRST set does the same to the register state.
`include "gpio_bank_irq_controller_macros.svh"

module gpio_bank_irq_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  gbic_pkg::gbic_req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output gbic_pkg::gbic_rsp_type rsp_data
);
   import gbic_pkg::*;

   gbic_req_type  item_ff, item_in;
   logic          item_vld_ff, item_vld_in;
   gbic_rsp_type  rsp_ff, rsp_in, rsp_calc;
   logic          rsp_vld_ff, rsp_vld_in;

   logic          sft_ff, sft_in;
   logic          gate_ff, gate_in;
   logic [31:0]   mux_ff   [NUM_MUX_REGS];
   logic [31:0]   mux_in   [NUM_MUX_REGS];
   logic [31:0]   mux_wr   [NUM_MUX_REGS];
   logic [31:0]   drive_ff [NUM_DRIVE_REGS];
   logic [31:0]   drive_in [NUM_DRIVE_REGS];
   logic [31:0]   drive_wr [NUM_DRIVE_REGS];
   logic [31:0]   pull_ff  [NUM_PULL_REGS];
   logic [31:0]   pull_in  [NUM_PULL_REGS];
   logic [31:0]   pull_wr  [NUM_PULL_REGS];
   gbic_bank_type bank_ff  [NUM_BANKS];
   gbic_bank_type bank_in  [NUM_BANKS];
   gbic_bank_type bank_wr  [NUM_BANKS];
   gbic_bank_type bank_rs  [NUM_BANKS];

   logic          adv, fire, req_acc;
   logic [3:0]    op;
   logic [4:0]    grp;
   logic [3:0]    idx;
   logic          is_rd, is_wr, is_pad;
   logic          ctrl_hit, mux_hit, drive_hit, pull_hit, bank_hit, known;
   logic [IRQ_W-1:0] lines_cur, lines_nx;
   logic [31:0]   ctrl_cur, ctrl_new, rd_val, vm;
   logic          soft_rst;

   // handshake
   always_comb begin
      adv         = !rsp_vld_ff || !rsp_stall;
      fire        = item_vld_ff && adv;
      req_stall   = item_vld_ff && !adv;
      req_acc     = req_valid && !req_stall;
      item_vld_in = req_acc ? 1'b1 : (fire ? 1'b0 : item_vld_ff);
      item_in     = req_acc ? req_data : item_ff;
      rsp_vld_in  = fire ? 1'b1 : (adv ? 1'b0 : rsp_vld_ff);
      rsp_in      = fire ? rsp_calc : rsp_ff;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   // decode, read and write
   always_comb begin
      op     = item_ff.offset[3:0];
      grp    = item_ff.offset[12:8];
      idx    = item_ff.offset[7:4];
      is_rd  = item_ff.req_type == REQ_READ;
      is_wr  = item_ff.req_type == REQ_WRITE;
      is_pad = item_ff.req_type == REQ_PAD;
      vm     = '0;

      ctrl_hit  = (grp == GRP_CTRL) && (idx == 4'd0);
      mux_hit   = (grp == GRP_MUX) && ({1'b0, idx} < 5'(NUM_MUX_REGS));
      drive_hit = (grp == GRP_DRIVE) && ({1'b0, idx} < 5'(NUM_DRIVE_REGS));
      pull_hit  = (grp == GRP_PULL) && ({1'b0, idx} < 5'(NUM_PULL_REGS));
      bank_hit  = (grp >= GRP_DOUT) && (grp <= GRP_IRQSTAT)
               && ({1'b0, idx} < 5'(NUM_BANKS));
      known     = ctrl_hit || mux_hit || drive_hit || pull_hit || bank_hit;

      lines_cur = '0;
      for (int b = 0; b < NUM_BANKS; b++) begin
         lines_cur[b] = |(bank_ff[b].stat & bank_ff[b].en & bank_ff[b].sel);
      end
      ctrl_cur = (sft_ff ? CTRL_SFT : 32'd0) | (gate_ff ? CTRL_GATE : 32'd0)
               | CTRL_PRESENT | 32'(lines_cur);
      ctrl_new = apply_op(ctrl_cur, CTRL_SFT | CTRL_GATE, item_ff.write_data, op);
      soft_rst = is_wr && ctrl_hit && ((ctrl_new & CTRL_SFT) != 32'd0);

      rd_val = ctrl_hit ? ctrl_cur : 32'd0;

      for (int k = 0; k < NUM_MUX_REGS; k++) begin
         mux_wr[k] = mux_ff[k];
         if (mux_hit && idx == 4'(k)) begin
            rd_val = mux_ff[k];
            if (is_wr) mux_wr[k] = apply_op(mux_ff[k], '1, item_ff.write_data, op);
         end
      end
      for (int k = 0; k < NUM_DRIVE_REGS; k++) begin
         drive_wr[k] = drive_ff[k];
         if (drive_hit && idx == 4'(k)) begin
            rd_val = drive_ff[k];
            if (is_wr) begin
               drive_wr[k] = apply_op(drive_ff[k], drive_fld_mask(k), item_ff.write_data, op);
            end
         end
      end
      for (int k = 0; k < NUM_PULL_REGS; k++) begin
         pull_wr[k] = pull_ff[k];
         if (pull_hit && idx == 4'(k)) begin
            rd_val = pull_ff[k];
            if (is_wr) begin
               pull_wr[k] = apply_op(pull_ff[k], pull_fld_mask(k), item_ff.write_data, op);
            end
         end
      end

      for (int b = 0; b < NUM_BANKS; b++) begin
         bank_wr[b] = bank_ff[b];
         if (is_pad && item_ff.pad_bank == 2'(b)) bank_wr[b].pad = item_ff.pad_levels;
         if (bank_hit && idx == 4'(b)) begin
            vm = valid_mask(b);
            unique case (grp)
               GRP_DOUT: begin
                  rd_val = bank_ff[b].dout;
                  if (is_wr) bank_wr[b].dout = apply_op(bank_ff[b].dout, vm,
                                                        item_ff.write_data, op);
               end
               GRP_DIN: begin
                  rd_val = bank_ff[b].pad | (bank_ff[b].dout & bank_ff[b].doe);
               end
               GRP_DOE: begin
                  rd_val = bank_ff[b].doe;
                  if (is_wr) bank_wr[b].doe = apply_op(bank_ff[b].doe, vm,
                                                       item_ff.write_data, op);
               end
               GRP_PIN2IRQ: begin
                  rd_val = bank_ff[b].sel;
                  if (is_wr) bank_wr[b].sel = apply_op(bank_ff[b].sel, vm,
                                                       item_ff.write_data, op);
               end
               GRP_IRQEN: begin
                  rd_val = bank_ff[b].en;
                  if (is_wr) bank_wr[b].en = apply_op(bank_ff[b].en, vm,
                                                      item_ff.write_data, op);
               end
               GRP_IRQLEVEL: begin
                  rd_val = bank_ff[b].lvl;
                  if (is_wr) bank_wr[b].lvl = apply_op(bank_ff[b].lvl, vm,
                                                       item_ff.write_data, op);
               end
               GRP_IRQPOL: begin
                  rd_val = bank_ff[b].pol;
                  if (is_wr) bank_wr[b].pol = apply_op(bank_ff[b].pol, vm,
                                                       item_ff.write_data, op);
               end
               GRP_IRQSTAT: begin
                  rd_val = bank_ff[b].stat;
                  // plain write only sets status bits
                  if (is_wr) begin
                     unique case (op)
                        OP_CLR:  bank_wr[b].stat = bank_ff[b].stat
                                                 & ~(item_ff.write_data & vm);
                        OP_TOG:  bank_wr[b].stat = bank_ff[b].stat
                                                 ^ (item_ff.write_data & vm);
                        default: bank_wr[b].stat = bank_ff[b].stat
                                                 | (item_ff.write_data & vm);
                     endcase
                  end
               end
               default: rd_val = '0;
            endcase
         end
      end
   end

   for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
      gbic_bank_irq u_bank_irq (
         .bank_pre  (bank_wr[b]),
         .pin_mask  (valid_mask(b)),
         .bank_post (bank_rs[b])
      );
   end

   // next state and result
   always_comb begin
      sft_in  = sft_ff;
      gate_in = gate_ff;
      for (int k = 0; k < NUM_MUX_REGS; k++)   mux_in[k]   = mux_ff[k];
      for (int k = 0; k < NUM_DRIVE_REGS; k++) drive_in[k] = drive_ff[k];
      for (int k = 0; k < NUM_PULL_REGS; k++)  pull_in[k]  = pull_ff[k];
      for (int b = 0; b < NUM_BANKS; b++)      bank_in[b]  = bank_ff[b];

      if (fire) begin
         for (int k = 0; k < NUM_MUX_REGS; k++)   mux_in[k]   = mux_wr[k];
         for (int k = 0; k < NUM_DRIVE_REGS; k++) drive_in[k] = drive_wr[k];
         for (int k = 0; k < NUM_PULL_REGS; k++)  pull_in[k]  = pull_wr[k];
         for (int b = 0; b < NUM_BANKS; b++) begin
            bank_in[b] = (is_wr || is_pad) ? bank_rs[b] : bank_wr[b];
         end
         if (is_wr && ctrl_hit) begin
            sft_in  = 1'b0;
            gate_in = (ctrl_new & CTRL_GATE) != 32'd0;
         end
         if (soft_rst) begin
            sft_in  = 1'b1;
            gate_in = 1'b1;
            for (int k = 0; k < NUM_MUX_REGS; k++)   mux_in[k]   = '0;
            for (int k = 0; k < NUM_DRIVE_REGS; k++)
               drive_in[k] = drive_fld_mask(k) & DRIVE_RESET_PAT;
            for (int k = 0; k < NUM_PULL_REGS; k++)  pull_in[k]  = '0;
            for (int b = 0; b < NUM_BANKS; b++)      bank_in[b]  = '0;
         end
      end

      lines_nx = '0;
      for (int b = 0; b < NUM_BANKS; b++) begin
         lines_nx[b] = |(bank_in[b].stat & bank_in[b].en & bank_in[b].sel);
      end
      rsp_calc.read_data    = (is_rd && known && op == OP_PLAIN) ? rd_val : 32'd0;
      rsp_calc.irq_lines    = lines_nx;
      rsp_calc.access_error = (is_rd || is_wr) && !known;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         sft_ff      <= 1'b1;
         gate_ff     <= 1'b1;
         for (int k = 0; k < NUM_MUX_REGS; k++)   mux_ff[k]   <= '0;
         for (int k = 0; k < NUM_DRIVE_REGS; k++)
            drive_ff[k] <= drive_fld_mask(k) & DRIVE_RESET_PAT;
         for (int k = 0; k < NUM_PULL_REGS; k++)  pull_ff[k]  <= '0;
         for (int b = 0; b < NUM_BANKS; b++)      bank_ff[b]  <= '0;
      end else begin
         item_vld_ff <= item_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
         sft_ff      <= sft_in;
         gate_ff     <= gate_in;
         for (int k = 0; k < NUM_MUX_REGS; k++)   mux_ff[k]   <= mux_in[k];
         for (int k = 0; k < NUM_DRIVE_REGS; k++) drive_ff[k] <= drive_in[k];
         for (int k = 0; k < NUM_PULL_REGS; k++)  pull_ff[k]  <= pull_in[k];
         for (int b = 0; b < NUM_BANKS; b++)      bank_ff[b]  <= bank_in[b];
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   `GBIC_ASSERT_IMP(a_hold_when_full, rsp_vld_ff && rsp_stall && item_vld_ff, req_stall)
   `GBIC_ASSERT_NXT(a_soft_reset, fire && soft_rst, sft_ff && gate_ff)
   `GBIC_ASSERT_NXT(a_no_err_on_pad, fire && !(is_rd || is_wr), !rsp_ff.access_error)
   `GBIC_ASSERT_NXT(a_alias_read_zero, fire && is_rd && op != OP_PLAIN, rsp_ff.read_data == 32'd0)
   `GBIC_ASSERT_IMP(a_empty_bank_quiet, rsp_vld_ff, !rsp_ff.irq_lines[IRQ_W-1])

endmodule
